// ===== design/tcw_pkg.sv =====
// Shared types and constants of the text console writer.
`default_nettype none
package tcw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam logic [7:0]  NEWLINE_CODE = 8'd10;
	localparam logic [7:0]  SPACE_CODE   = 8'd32;
	localparam logic [7:0]  RESET_COLOR  = 8'h07;
	localparam logic [15:0] RESET_CELL   = 16'h0720;

	localparam logic MODE_PUT  = 1'b0;
	localparam logic MODE_READ = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RESP,
		ST_SCROLL,
		ST_BLANK
	} tcw_state_t;

	typedef struct packed {
		logic accept;
		logic clear_step;
		logic scroll_step;
		logic blank_en;
		logic out_load;
	} tcw_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic scroll_last;
		logic blank_last;
		logic need_scroll;
		logic out_free;
	} tcw_sts_t;

endpackage
`default_nettype wire

// ===== design/tcw_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== design/tcw_ctrl.sv =====
// Controller state machine of the text console writer.
`default_nettype none
module tcw_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              s_tvalid,
	output logic             s_tready,
	input  tcw_pkg::tcw_sts_t sts,
	output tcw_pkg::tcw_cmd_t cmd
);

	tcw_pkg::tcw_state_t state_q;
	tcw_pkg::tcw_state_t state_nxt;
	logic                accept;

	assign accept = s_tvalid && (state_q == tcw_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcw_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			tcw_pkg::ST_CLEAR: begin
				if (sts.clear_last) state_nxt = tcw_pkg::ST_IDLE;
			end
			tcw_pkg::ST_IDLE: begin
				if (accept) begin
					state_nxt = sts.need_scroll ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_RESP;
				end
			end
			tcw_pkg::ST_RESP: begin
				if (sts.out_free) state_nxt = tcw_pkg::ST_IDLE;
			end
			tcw_pkg::ST_SCROLL: begin
				if (sts.scroll_last) state_nxt = tcw_pkg::ST_BLANK;
			end
			tcw_pkg::ST_BLANK: begin
				if (sts.blank_last) state_nxt = tcw_pkg::ST_RESP;
			end
			default: state_nxt = tcw_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		s_tready        = (state_q == tcw_pkg::ST_IDLE);
		cmd.accept      = accept;
		cmd.clear_step  = (state_q == tcw_pkg::ST_CLEAR);
		cmd.scroll_step = (state_q == tcw_pkg::ST_SCROLL);
		cmd.blank_en    = (state_q == tcw_pkg::ST_BLANK);
		cmd.out_load    = (state_q == tcw_pkg::ST_RESP) && sts.out_free;
	end

endmodule
`default_nettype wire

// ===== design/tcw_dp.sv =====
// Datapath of the text console writer: cursor, color, screen store and result register.
`default_nettype none
module tcw_dp #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               s_tuser,
	input  wire [23:0]        s_tdata,
	output logic              m_tvalid,
	input  wire               m_tready,
	output logic [31:0]       m_tdata,
	input  wire               cfg_valid,
	input  wire [7:0]         cfg_data,
	input  tcw_pkg::tcw_cmd_t cmd,
	output tcw_pkg::tcw_sts_t sts
);

	localparam int CELL_COUNT = ROWS * COLUMNS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int ROW_W      = $clog2(ROWS);
	localparam int COL_W      = $clog2(COLUMNS);

	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [7:0]        color_q;
	logic [ADDR_W-1:0] cnt_q;
	logic              wr_pend_s1;
	logic [ADDR_W-1:0] wr_addr_s1;
	logic              rd_hit_q;
	logic              out_valid_q;
	logic [31:0]       out_data_q;

	logic [7:0]        in_char;
	logic [10:0]       in_index;
	logic              is_put;
	logic              is_newline;
	logic              row_last;
	logic              col_last;
	logic              in_range;
	logic [ADDR_W-1:0] cur_addr;
	logic              cnt_end;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [15:0]       wdata;
	logic              re;
	logic [ADDR_W-1:0] raddr;
	logic [15:0]       rdata;
	logic [15:0]       entry;
	logic [31:0]       row_ext;
	logic [31:0]       col_ext;

	assign in_char    = s_tdata[7:0];
	assign in_index   = s_tdata[18:8];
	assign is_put     = (s_tuser == tcw_pkg::MODE_PUT);
	assign is_newline = (in_char == tcw_pkg::NEWLINE_CODE);
	assign row_last   = (row_q == ROW_W'(ROWS - 1));
	assign col_last   = (col_q == COL_W'(COLUMNS - 1));
	assign in_range   = (32'(in_index) < CELL_COUNT);
	assign cur_addr   = ADDR_W'(32'(row_q) * COLUMNS + 32'(col_q));
	assign cnt_end    = (cnt_q == ADDR_W'(CELL_COUNT - 1));

	assign sts.clear_last  = cmd.clear_step && cnt_end;
	assign sts.scroll_last = cmd.scroll_step && (cnt_q == ADDR_W'(CELL_COUNT - COLUMNS - 1));
	assign sts.blank_last  = cmd.blank_en && !wr_pend_s1 && cnt_end;
	assign sts.need_scroll = is_put && (is_newline || col_last) && row_last;
	assign sts.out_free    = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= tcw_pkg::RESET_COLOR;
		end else if (cfg_valid) begin
			color_q <= cfg_data;
		end
	end

	// Cursor moves when a put request is taken; a scroll leaves it on the bottom row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cmd.accept && is_put) begin
			if (is_newline || col_last) begin
				col_q <= '0;
				if (!row_last) row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// One counter serves the clearing pass, the row copy and the bottom row blanking.
	// The copy ends one cell before the bottom row, where blanking starts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			wr_pend_s1 <= 1'b0;
		end else begin
			wr_pend_s1 <= cmd.scroll_step;
			if (cmd.clear_step || (cmd.blank_en && !wr_pend_s1)) begin
				cnt_q <= cnt_end ? '0 : cnt_q + 1'b1;
			end else if (cmd.scroll_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= cnt_q;
		if (cmd.accept) rd_hit_q <= !is_put && in_range;
	end

	always_comb begin
		we    = 1'b0;
		waddr = cur_addr;
		wdata = {color_q, in_char};
		priority if (wr_pend_s1) begin
			we    = 1'b1;
			waddr = wr_addr_s1;
			wdata = rdata;
		end else if (cmd.clear_step) begin
			we    = 1'b1;
			waddr = cnt_q;
			wdata = tcw_pkg::RESET_CELL;
		end else if (cmd.blank_en) begin
			we    = 1'b1;
			waddr = cnt_q;
			wdata = {color_q, tcw_pkg::SPACE_CODE};
		end else if (cmd.accept && is_put && !is_newline) begin
			we = 1'b1;
		end else begin
			we = 1'b0;
		end
	end

	assign re    = cmd.scroll_step || (cmd.accept && !is_put);
	assign raddr = cmd.scroll_step ? cnt_q + ADDR_W'(COLUMNS) : ADDR_W'(32'(in_index));

	tcw_ram #(
		.WIDTH(16),
		.DEPTH(CELL_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign entry   = rd_hit_q ? rdata : 16'd0;
	assign row_ext = 32'(row_q);
	assign col_ext = 32'(col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) out_data_q <= {4'd0, col_ext[6:0], row_ext[4:0], entry};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
`default_nettype wire

// ===== design/text_console_writer.sv =====
// Text console writer: a character screen store with a cursor and scrolling.
//
// Requests enter on the s_ channel: s_tuser selects a put (0) or a cell read (1).
// A put writes the character in the current color at the cursor and advances it;
// a newline moves the cursor to the start of the next row. One result per request
// leaves on the m_ channel with the read cell (zero on a put) and the cursor.
// The user must write the color register on the cfg_ channel only while the block
// is idle; the block itself does not enforce this. A request is taken only in the
// idle state; the controller then passes through the response state, where the
// result is loaded into the output register, before it takes the next request.
// A put that moves past the last row scrolls: each row is copied up one row and the
// bottom row is then blanked in the current color, during which no request is taken.
// After reset the store is filled with grey spaces before the first request is taken;
// the cursor is at the top left. A result that is not taken holds in the output
// register; the block still finishes the request in flight but takes no further
// one until it frees up.
`default_nettype none
module text_console_writer #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire [23:0]  s_tdata,   // char_code[7:0], cell_index[18:8], zero pad
	input  wire         s_tuser,   // mode[0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // cell_entry[15:0], cursor_row[20:16],
	                               // cursor_col[27:21], zero pad
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire [7:0]   cfg_data   // text_color
);

	tcw_pkg::tcw_cmd_t cmd;
	tcw_pkg::tcw_sts_t sts;

	assign cfg_ready = 1'b1;

	tcw_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	tcw_dp #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule
`default_nettype wire
